/* src/ihb_pkg.sv */
package ihb_pkg;

  // Default edge length of the stored cube
  localparam int LATTICE_SIZE_DEFAULT = 16;

  // Field widths
  localparam int COORD_W  = 4;
  localparam int EDGE_W   = 5;
  localparam int PROB_W   = 16;
  localparam int RND_W    = 16;
  localparam int NSUM_W   = 4;
  localparam int DE_W     = 5;
  localparam int ENERGY_W = 16;
  localparam int MAG_W    = 15;

  // Largest edge the coordinate fields can address
  localparam int MAX_EDGE = 1 << COORD_W;
  localparam int MIN_EDGE = 2;

  // Saturation limits of the running sums
  localparam int ENERGY_LIMIT = 24576;
  localparam int MAG_LIMIT    = 8192;

  // Stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_PROB    = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_LATTICE_SIZE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PROB_FIRST   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PROB_LAST    = 3'd7;

  // Lattice row reads: center row and the four x/y neighbor rows
  localparam int NUM_ROWS = 5;
  localparam int ROW_C    = 0;
  localparam int ROW_XM   = 1;
  localparam int ROW_XP   = 2;
  localparam int ROW_YM   = 3;
  localparam int ROW_YP   = 4;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [EDGE_W-1:0]  edge_t;
  typedef logic [PROB_W-1:0]  prob_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  localparam edge_t LATTICE_SIZE_RESET = 5'd16;
  localparam prob_t [NUM_PROB-1:0] PROB_RESET = {
    16'd65535, 16'd65535, 16'd65535, 16'd32768, 16'd0, 16'd0, 16'd0
  };

  // Clamped site and its wrapped neighbors
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t xm;
    coord_t xp;
    coord_t ym;
    coord_t yp;
    coord_t zm;
    coord_t zp;
  } site_t;

  // Control for the update stage, including forwarding from the last write
  typedef struct packed {
    op_t                  op;
    logic                 spin_value;
    logic [RND_W-1:0]     random_value;
    coord_t               z;
    coord_t               zm;
    coord_t               zp;
    logic [NUM_ROWS-1:0]  hit;
    logic                 fwd_bit;
    coord_t               fwd_z;
  } upd_in_t;

  // Result, packed from the top field down to new_spin in bit 0
  typedef struct packed {
    logic signed [MAG_W-1:0]    magnetization_sum;
    logic signed [ENERGY_W-1:0] energy_sum;
    logic signed [DE_W-1:0]     energy_change;
    logic signed [NSUM_W-1:0]   neighbour_sum;
    logic                       flipped;
    logic                       new_spin;
  } result_t;

endpackage

/* src/ihb_site.sv */
module ihb_site (
  input  ihb_pkg::edge_t  edge_len,
  input  ihb_pkg::coord_t x,
  input  ihb_pkg::coord_t y,
  input  ihb_pkg::coord_t z,
  output ihb_pkg::site_t  site
);
  import ihb_pkg::*;

  // Saturate a coordinate to the last site of the edge
  function automatic coord_t clamp_c(coord_t c, edge_t l);
    return (EDGE_W'(c) >= l) ? COORD_W'(l - edge_t'(1)) : c;
  endfunction

  // Periodic predecessor
  function automatic coord_t wrap_dec(coord_t c, edge_t l);
    return (c == '0) ? COORD_W'(l - edge_t'(1)) : c - coord_t'(1);
  endfunction

  // Periodic successor, compared at edge width so the top edge wraps cleanly
  function automatic coord_t wrap_inc(coord_t c, edge_t l);
    return ((EDGE_W'(c) + edge_t'(1)) == l) ? '0 : c + coord_t'(1);
  endfunction

  coord_t cx, cy, cz;

  always_comb begin
    cx = clamp_c(x, edge_len);
    cy = clamp_c(y, edge_len);
    cz = clamp_c(z, edge_len);
  end

  always_comb begin
    site.x  = cx;
    site.y  = cy;
    site.z  = cz;
    site.xm = wrap_dec(cx, edge_len);
    site.xp = wrap_inc(cx, edge_len);
    site.ym = wrap_dec(cy, edge_len);
    site.yp = wrap_inc(cy, edge_len);
    site.zm = wrap_dec(cz, edge_len);
    site.zp = wrap_inc(cz, edge_len);
  end

endmodule

/* src/ihb_lattice_ram.sv */
module ihb_lattice_ram #(
  parameter int ROW_W = ihb_pkg::LATTICE_SIZE_DEFAULT,
  parameter int DEPTH = ihb_pkg::LATTICE_SIZE_DEFAULT * ihb_pkg::LATTICE_SIZE_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [$clog2(ROW_W)-1:0] wr_sel,
  input  logic                     wr_bit,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [ROW_W-1:0]         rd_data
);

  // One row holds a full z column; writes touch a single bit
  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][wr_sel] <= wr_bit;
    end
  end

  // Registered read, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/ihb_update.sv */
module ihb_update #(
  parameter int LATTICE_SIZE = ihb_pkg::LATTICE_SIZE_DEFAULT
) (
  input  logic [ihb_pkg::NUM_ROWS-1:0][LATTICE_SIZE-1:0] rows,
  input  ihb_pkg::upd_in_t                               ctl,
  input  ihb_pkg::prob_t [ihb_pkg::NUM_PROB-1:0]         prob,
  input  logic signed [ihb_pkg::ENERGY_W-1:0]            energy_acc,
  input  logic signed [ihb_pkg::MAG_W-1:0]               mag_acc,
  output ihb_pkg::result_t                               res
);
  import ihb_pkg::*;

  localparam int ZW = $clog2(LATTICE_SIZE);
  localparam logic signed [ENERGY_W:0] E_HI = (ENERGY_W+1)'(ENERGY_LIMIT);
  localparam logic signed [ENERGY_W:0] E_LO = -E_HI;
  localparam logic signed [MAG_W:0]    M_HI = (MAG_W+1)'(MAG_LIMIT);
  localparam logic signed [MAG_W:0]    M_LO = -M_HI;

  logic [NUM_ROWS-1:0][LATTICE_SIZE-1:0] fixed;
  logic [ZW-1:0]                 zi, zmi, zpi;
  logic                          old_bit, up_bit, flip;
  logic [2:0]                    up_count;
  prob_t                         thr;
  logic signed [NSUM_W-1:0]      nsum;
  logic signed [DE_W-1:0]        twice_sum, de;
  logic signed [ENERGY_W:0]      e_wide, e_sat;
  logic signed [MAG_W:0]         m_wide, m_sat;

  assign zi  = ZW'(ctl.z);
  assign zmi = ZW'(ctl.zm);
  assign zpi = ZW'(ctl.zp);

  // Patch in the bit written by the previous item where its row was read stale
  always_comb begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      fixed[i] = rows[i];
      if (ctl.hit[i]) begin
        fixed[i][ZW'(ctl.fwd_z)] = ctl.fwd_bit;
      end
    end
  end

  // Neighbor count and heat-bath decision
  always_comb begin
    old_bit  = fixed[ROW_C][zi];
    up_count = 3'(fixed[ROW_C][zmi]) + 3'(fixed[ROW_C][zpi])
             + 3'(fixed[ROW_XM][zi]) + 3'(fixed[ROW_XP][zi])
             + 3'(fixed[ROW_YM][zi]) + 3'(fixed[ROW_YP][zi]);
    thr       = prob[up_count];
    nsum      = $signed({up_count, 1'b0} - 4'd6);
    up_bit    = ctl.random_value < thr;
    flip      = up_bit != old_bit;
    twice_sum = $signed({nsum, 1'b0});
    if (!flip) begin
      de = '0;
    end else if (up_bit) begin
      de = -twice_sum;
    end else begin
      de = twice_sum;
    end
  end

  // Saturating running sums
  always_comb begin
    e_wide = $signed({energy_acc[ENERGY_W-1], energy_acc})
           + $signed({{(ENERGY_W+1-DE_W){de[DE_W-1]}}, de});
    m_wide = $signed({mag_acc[MAG_W-1], mag_acc})
           + (up_bit ? (MAG_W+1)'(2) : -(MAG_W+1)'(2));
    if (e_wide > E_HI) begin
      e_sat = E_HI;
    end else if (e_wide < E_LO) begin
      e_sat = E_LO;
    end else begin
      e_sat = e_wide;
    end
    if (m_wide > M_HI) begin
      m_sat = M_HI;
    end else if (m_wide < M_LO) begin
      m_sat = M_LO;
    end else begin
      m_sat = m_wide;
    end
  end

  // Result: a write reports its bit and clears the sums
  always_comb begin
    if (ctl.op == OP_WRITE) begin
      res.new_spin          = ctl.spin_value;
      res.flipped           = 1'b0;
      res.neighbour_sum     = '0;
      res.energy_change     = '0;
      res.energy_sum        = '0;
      res.magnetization_sum = '0;
    end else begin
      res.new_spin          = up_bit;
      res.flipped           = flip;
      res.neighbour_sum     = nsum;
      res.energy_change     = de;
      res.energy_sum        = flip ? ENERGY_W'(e_sat) : energy_acc;
      res.magnetization_sum = flip ? MAG_W'(m_sat) : mag_acc;
    end
  end

endmodule

/* src/ising_3d_heat_bath_update.sv */
// Channel  Dir  Width  Contents
// s_*      in   32+1   site request: coordinates, spin to write, random fraction; op in tuser
// m_*      out  48     result: spin, flip flag, neighbor sum, energy change, running sums
// cfg_*    in   3+16   register writes: edge length, seven up thresholds
//
// One item per cycle with m_tready high; each passes input, read-data and result registers.
// The rate is set by the lattice row memories (one read and one bit write per cycle,
// five copies), with the previous item's write forwarded into stale reads.
// Reset (rst, synchronous) clears the pipeline and both sums, and loads register defaults;
// the lattice is not cleared and must be written before it is read.
// With m_tready low the result holds; earlier stages fill, then s_tready drops.
module ising_3d_heat_bath_update #(
  parameter int LATTICE_SIZE = ihb_pkg::LATTICE_SIZE_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // site_x[3:0], site_y[7:4], site_z[11:8], spin_value[12], random_value[28:13], zeros
  input  logic [ihb_pkg::IN_TDATA_W-1:0]      s_tdata,
  // operation[0]
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // new_spin[0], flipped[1], neighbour_sum[5:2], energy_change[10:6],
  // energy_sum[26:11], magnetization_sum[41:27], zeros
  output logic [ihb_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_write,
  input  logic [ihb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ihb_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ihb_pkg::*;

  localparam int DEPTH    = LATTICE_SIZE * LATTICE_SIZE;
  localparam int AW       = $clog2(DEPTH);
  localparam int ZW       = $clog2(LATTICE_SIZE);
  localparam int EDGE_TOP = (LATTICE_SIZE < MAX_EDGE) ? LATTICE_SIZE : MAX_EDGE;
  localparam logic signed [ENERGY_W-1:0] E_LIM = ENERGY_W'(ENERGY_LIMIT);
  localparam logic signed [MAG_W-1:0]    M_LIM = MAG_W'(MAG_LIMIT);

  function automatic logic [AW-1:0] row_addr(coord_t a, coord_t b);
    return AW'(a) * AW'(LATTICE_SIZE) + AW'(b);
  endfunction

  // Configuration registers
  edge_t                  lattice_size;
  prob_t [NUM_PROB-1:0]   prob;
  edge_t                  edge_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_size <= LATTICE_SIZE_RESET;
      prob         <= PROB_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_LATTICE_SIZE) begin
        lattice_size <= cfg_data[EDGE_W-1:0];
      end else if (cfg_index >= REG_PROB_FIRST && cfg_index <= REG_PROB_LAST) begin
        prob[CFG_INDEX_W'(cfg_index - REG_PROB_FIRST)] <= cfg_data;
      end
    end
  end

  // Edge length in use
  always_comb begin
    if (lattice_size < edge_t'(MIN_EDGE)) begin
      edge_len = edge_t'(MIN_EDGE);
    end else if (lattice_size > edge_t'(EDGE_TOP)) begin
      edge_len = edge_t'(EDGE_TOP);
    end else begin
      edge_len = lattice_size;
    end
  end

  // Handshake and stage enables
  logic v1, v2;
  logic en1, en2, en_out, wr_en;

  assign en_out   = !m_tvalid || m_tready;
  assign en2      = !v2 || en_out;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign wr_en    = v2 && en_out;

  // Site clamp and neighbor wrap on the incoming request
  site_t site_in;

  ihb_site u_site (
    .edge_len (edge_len),
    .x        (s_tdata[3:0]),
    .y        (s_tdata[7:4]),
    .z        (s_tdata[11:8]),
    .site     (site_in)
  );

  // Stage 1: input register
  site_t             s1;
  op_t               op1;
  logic              spin1;
  logic [RND_W-1:0]  rnd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1    <= site_in;
      op1   <= op_t'(s_tuser[0]);
      spin1 <= s_tdata[12];
      rnd1  <= s_tdata[28:13];
    end
  end

  // Row addresses for the five reads and the write
  logic [NUM_ROWS-1:0][AW-1:0]           raddr;
  logic [NUM_ROWS-1:0][LATTICE_SIZE-1:0] rows;
  logic [NUM_ROWS-1:0]                   hit_next;
  logic [AW-1:0]                         waddr;
  site_t                                 s2;
  result_t                               res;

  assign raddr[ROW_C]  = row_addr(s1.x,  s1.y);
  assign raddr[ROW_XM] = row_addr(s1.xm, s1.y);
  assign raddr[ROW_XP] = row_addr(s1.xp, s1.y);
  assign raddr[ROW_YM] = row_addr(s1.x,  s1.ym);
  assign raddr[ROW_YP] = row_addr(s1.x,  s1.yp);
  assign waddr         = row_addr(s2.x,  s2.y);

  // Rows read now miss the write landing on the same edge
  always_comb begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      hit_next[i] = wr_en && (raddr[i] == waddr);
    end
  end

  // Replicated lattice row memories
  for (genvar g = 0; g < NUM_ROWS; g++) begin : g_ram
    ihb_lattice_ram #(
      .ROW_W (LATTICE_SIZE),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (waddr),
      .wr_sel  (ZW'(s2.z)),
      .wr_bit  (res.new_spin),
      .rd_en   (en2),
      .rd_addr (raddr[g]),
      .rd_data (rows[g])
    );
  end

  // Stage 2: read data stage
  op_t                  op2;
  logic                 spin2;
  logic [RND_W-1:0]     rnd2;
  logic [NUM_ROWS-1:0]  hit2;
  logic                 fbit2;
  coord_t               fz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2    <= s1;
      op2   <= op1;
      spin2 <= spin1;
      rnd2  <= rnd1;
      hit2  <= hit_next;
      fbit2 <= res.new_spin;
      fz2   <= s2.z;
    end
  end

  // Decision and sums
  upd_in_t                    upd_ctl;
  logic signed [ENERGY_W-1:0] energy_acc;
  logic signed [MAG_W-1:0]    mag_acc;

  always_comb begin
    upd_ctl.op           = op2;
    upd_ctl.spin_value   = spin2;
    upd_ctl.random_value = rnd2;
    upd_ctl.z            = s2.z;
    upd_ctl.zm           = s2.zm;
    upd_ctl.zp           = s2.zp;
    upd_ctl.hit          = hit2;
    upd_ctl.fwd_bit      = fbit2;
    upd_ctl.fwd_z        = fz2;
  end

  ihb_update #(
    .LATTICE_SIZE (LATTICE_SIZE)
  ) u_update (
    .rows       (rows),
    .ctl        (upd_ctl),
    .prob       (prob),
    .energy_acc (energy_acc),
    .mag_acc    (mag_acc),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_acc <= '0;
      mag_acc    <= '0;
    end else if (wr_en) begin
      energy_acc <= res.energy_sum;
      mag_acc    <= res.magnetization_sum;
    end
  end

  // Result register
  result_t res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      res_q <= res;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - $bits(result_t))'(0), res_q};

  // A write clears both sums
  a_write_clears: assert property (@(posedge clk) disable iff (rst)
    (wr_en && op2 == OP_WRITE) |=> (energy_acc == '0 && mag_acc == '0))
    else $error("sums not cleared after a spin write");

  // Sums stay within their saturation limits
  a_energy_bound: assert property (@(posedge clk) disable iff (rst)
    (energy_acc <= E_LIM && energy_acc >= -E_LIM))
    else $error("energy sum outside its limit");

  a_mag_bound: assert property (@(posedge clk) disable iff (rst)
    (mag_acc <= M_LIM && mag_acc >= -M_LIM))
    else $error("magnetization sum outside its limit");

  // No flip, no energy change
  a_still_no_energy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res_q.flipped) |-> (res_q.energy_change == '0))
    else $error("energy change reported without a flip");

endmodule

/* tb/tb_top.sv */
module tb_top;
  import ihb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int CYCLE_LIMIT = 20000;
  localparam int CALM_START  = 500;
  localparam int CALM_END    = 950;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int NUM_PHASES  = 12;
  // Edge lengths written per phase; 0, 1 and 31 exercise the saturation
  localparam int EDGE_PLAN [NUM_PHASES] = '{2, 3, 4, 0, 16, 5, 1, 31, 8, 2, 16, 3};

  typedef struct packed {
    op_t              op;
    coord_t           x;
    coord_t           y;
    coord_t           z;
    logic             spin;
    logic [RND_W-1:0] frac;
  } site_req_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [0:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Requests waiting to be sent, results waiting to arrive
  site_req_t site_reqs[$];
  result_t   results_due[$];

  // Mirror of the block: registers, lattice and running sums
  edge_t edge_reg;
  prob_t up_thr [0:NUM_PROB-1];
  bit    spin_mirror [0:4095];
  int    energy_run;
  int    magnet_run;

  // Sites written so far, tracked while requests are generated
  bit    site_loaded [0:4095];

  int errors;
  int cyc;
  int quiet;
  bit req_took;

  ising_3d_heat_bath_update u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lattice geometry
  function automatic int edge_len();
    int l;
    l = edge_reg;
    if (l < MIN_EDGE) l = MIN_EDGE;
    if (l > MAX_EDGE) l = MAX_EDGE;
    if (l > LATTICE_SIZE_DEFAULT) l = LATTICE_SIZE_DEFAULT;
    return l;
  endfunction

  function automatic int clamp_coord(int c, int l);
    return (c >= l) ? l - 1 : c;
  endfunction

  function automatic int wrap_dn(int c, int l);
    return (c == 0) ? l - 1 : c - 1;
  endfunction

  function automatic int wrap_up(int c, int l);
    return (c + 1 == l) ? 0 : c + 1;
  endfunction

  function automatic int lat_idx(int x, int y, int z);
    return (x * LATTICE_SIZE_DEFAULT + y) * LATTICE_SIZE_DEFAULT + z;
  endfunction

  function automatic int spin_pm(int x, int y, int z);
    return spin_mirror[lat_idx(x, y, z)] ? 1 : -1;
  endfunction

  function automatic int clamp_sum(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Heat-bath step on the mirror; returns the result the block should give
  function automatic result_t heat_bath_predict(site_req_t r);
    result_t res;
    int l, x, y, z, nsum, oldv, nw, de;
    bit up;
    l = edge_len();
    x = clamp_coord(r.x, l);
    y = clamp_coord(r.y, l);
    z = clamp_coord(r.z, l);
    res = '0;
    if (r.op == OP_WRITE) begin
      spin_mirror[lat_idx(x, y, z)] = r.spin;
      energy_run = 0;
      magnet_run = 0;
      res.new_spin = r.spin;
    end else begin
      oldv = spin_pm(x, y, z);
      nsum = spin_pm(wrap_dn(x, l), y, z) + spin_pm(wrap_up(x, l), y, z)
           + spin_pm(x, wrap_dn(y, l), z) + spin_pm(x, wrap_up(y, l), z)
           + spin_pm(x, y, wrap_dn(z, l)) + spin_pm(x, y, wrap_up(z, l));
      up = r.frac < up_thr[(nsum + 6) / 2];
      nw = up ? 1 : -1;
      spin_mirror[lat_idx(x, y, z)] = up;
      res.new_spin = up;
      res.neighbour_sum = NSUM_W'(nsum);
      if (nw != oldv) begin
        de = -nsum * (nw - oldv);
        res.flipped = 1'b1;
        res.energy_change = DE_W'(de);
        energy_run = clamp_sum(energy_run + de, ENERGY_LIMIT);
        magnet_run = clamp_sum(magnet_run + nw - oldv, MAG_LIMIT);
      end
    end
    res.energy_sum = ENERGY_W'(energy_run);
    res.magnetization_sum = MAG_W'(magnet_run);
    return res;
  endfunction

  // Random pause on either side, none inside the calm window
  function automatic bit take_break();
    return (cyc < CALM_START || cyc >= CALM_END) && ($urandom_range(0, 99) < 7);
  endfunction

  // Request generation
  function automatic site_req_t make_req(op_t op, int x, int y, int z, bit spin,
                                         logic [RND_W-1:0] frac);
    site_req_t r;
    r.op = op;
    r.x = coord_t'(x);
    r.y = coord_t'(y);
    r.z = coord_t'(z);
    r.spin = spin;
    r.frac = frac;
    return r;
  endfunction

  task automatic push_write(int x, int y, int z, bit spin);
    int l;
    l = edge_len();
    site_loaded[lat_idx(clamp_coord(x, l), clamp_coord(y, l), clamp_coord(z, l))] = 1'b1;
    site_reqs.push_back(make_req(OP_WRITE, x, y, z, spin, RND_W'($urandom)));
  endtask

  // Update; any of the seven sites it reads that is still unwritten gets a write first
  task automatic push_update(int x, int y, int z, logic [RND_W-1:0] frac);
    int l, cx, cy, cz;
    int nx [7];
    int ny [7];
    int nz [7];
    l = edge_len();
    cx = clamp_coord(x, l);
    cy = clamp_coord(y, l);
    cz = clamp_coord(z, l);
    nx = '{cx, wrap_dn(cx, l), wrap_up(cx, l), cx, cx, cx, cx};
    ny = '{cy, cy, cy, wrap_dn(cy, l), wrap_up(cy, l), cy, cy};
    nz = '{cz, cz, cz, cz, cz, wrap_dn(cz, l), wrap_up(cz, l)};
    for (int k = 0; k < 7; k++) begin
      if (!site_loaded[lat_idx(nx[k], ny[k], nz[k])])
        push_write(nx[k], ny[k], nz[k], $urandom_range(0, 1));
    end
    site_reqs.push_back(make_req(OP_UPDATE, x, y, z, $urandom_range(0, 1), frac));
  endtask

  // Mostly near the wrap corner on big cubes, any coordinate otherwise
  function automatic int pick_coord(int l);
    int pick;
    if (l <= 4 || $urandom_range(0, 9) < 3) return $urandom_range(0, 15);
    pick = $urandom_range(0, 4);
    return (pick < 3) ? pick : l - (pick - 2);
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_LATTICE_SIZE) edge_reg = val[EDGE_W-1:0];
    else up_thr[idx - REG_PROB_FIRST] = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Hold until every request is answered, then let the pipeline settle
  task automatic drain();
    while (site_reqs.size() != 0 || results_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Request driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !req_took)) begin
      if (site_reqs.size() != 0 && !take_break()) begin
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({site_reqs[0].frac, site_reqs[0].spin,
                                 site_reqs[0].z, site_reqs[0].y, site_reqs[0].x});
        s_tuser  <= site_reqs[0].op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Accepted request: predict its result
  always @(posedge clk) begin
    req_took = !rst && s_tvalid && s_tready;
    if (req_took) begin
      results_due.push_back(heat_bath_predict(site_reqs[0]));
      site_reqs.delete(0);
    end
  end

  // Result side backpressure
  always @(negedge clk) begin
    m_tready <= !take_break();
  end

  // Result checker
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t ERROR: result with nothing pending, actual %h", $time, m_tdata);
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t ERROR: expected spin=%0d flip=%0d nsum=%0d de=%0d esum=%0d msum=%0d",
                   $time, want.new_spin, want.flipped, want.neighbour_sum,
                   want.energy_change, want.energy_sum, want.magnetization_sum);
          $display("%0t        actual   spin=%0d flip=%0d nsum=%0d de=%0d esum=%0d msum=%0d",
                   $time, got.new_spin, got.flipped, got.neighbour_sum,
                   got.energy_change, got.energy_sum, got.magnetization_sum);
        end
      end
    end
  end

  // Watchdog on cycles with no traffic, with an overall cycle cap
  always @(posedge clk) begin
    cyc++;
    if (rst || cfg_write || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT || cyc >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int l, t, x, y, z;
    logic [RND_W-1:0] frac;
    edge_reg = LATTICE_SIZE_RESET;
    for (int k = 0; k < NUM_PROB; k++) up_thr[k] = PROB_RESET[k];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Low corner with all six wrapped neighbors up
    push_write(0, 0, 0, 1'b1);
    push_write(15, 0, 0, 1'b1);
    push_write(1, 0, 0, 1'b1);
    push_write(0, 15, 0, 1'b1);
    push_write(0, 1, 0, 1'b1);
    push_write(0, 0, 15, 1'b1);
    push_write(0, 0, 1, 1'b1);
    // full threshold: top fraction stays down, one below goes up
    push_update(0, 0, 0, 16'hFFFF);
    push_update(0, 0, 0, 16'hFFFE);
    push_update(0, 0, 0, 16'h0000);
    // High corner with all neighbors down, zero threshold
    push_write(15, 15, 15, 1'b0);
    push_write(14, 15, 15, 1'b0);
    push_write(0, 15, 15, 1'b0);
    push_write(15, 14, 15, 1'b0);
    push_write(15, 0, 15, 1'b0);
    push_write(15, 15, 14, 1'b0);
    push_write(15, 15, 0, 1'b0);
    push_update(15, 15, 15, 16'h0000);
    push_update(15, 15, 15, 16'hFFFF);
    push_write(15, 15, 15, 1'b1);
    push_update(15, 15, 15, 16'h0000);
    push_update(0, 0, 0, 16'h8000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      // junk above the edge field must be dropped
      write_reg(REG_LATTICE_SIZE,
                CFG_DATA_W'(EDGE_PLAN[p] | ($urandom_range(0, 2047) << EDGE_W)));
      for (int k = 0; k < NUM_PROB; k++) begin
        case (p % 4)
          0: t = 0;
          1: t = 65535;
          2: begin
            t = k * 10922 + $urandom_range(0, 4000);
            if (t > 65535) t = 65535;
          end
          default: t = $urandom_range(0, 65535);
        endcase
        write_reg(CFG_INDEX_W'(REG_PROB_FIRST + k), prob_t'(t));
      end
      l = edge_len();

      // Small cubes are loaded whole so updates run long without a write
      if (l <= 4) begin
        for (int i = 0; i < l; i++)
          for (int j = 0; j < l; j++)
            for (int k = 0; k < l; k++)
              push_write(i, j, k, $urandom_range(0, 1));
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        x = pick_coord(l);
        y = pick_coord(l);
        z = pick_coord(l);
        if ($urandom_range(0, 99) < 5) begin
          push_write(x, y, z, $urandom_range(0, 1));
        end else begin
          // fractions around the thresholds hit the compare boundary
          case ($urandom_range(0, 9))
            0: frac = '0;
            1: frac = '1;
            2, 3: frac = up_thr[$urandom_range(0, NUM_PROB - 1)]
                         + RND_W'($urandom_range(0, 2)) - RND_W'(1);
            default: frac = RND_W'($urandom);
          endcase
          push_update(x, y, z, frac);
        end
      end
    end

    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
src/ihb_pkg.sv
src/ihb_site.sv
src/ihb_lattice_ram.sv
src/ihb_update.sv
src/ising_3d_heat_bath_update.sv
tb/tb_top.sv
